// ===== rtl/ucdc_pkg.sv =====
package ucdc_pkg;

  localparam int CODE_LIMIT_DEF  = 255;
  localparam int FIRST_FREE_CODE = 1;

  localparam logic [7:0] FULL_CODE = 8'hFF;

  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_DECODE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic        active;
    logic        hit;
    logic [7:0]  code;
    logic [31:0] bytes;
    logic [2:0]  len;
  } tok_t;

  typedef struct packed {
    logic        is_enc;
    logic        is_dec;
    logic [31:0] key_val;
    logic [2:0]  key_len;
    logic [7:0]  code_in;
    logic [7:0]  next_code;
    logic        we;
  } bcast_t;

  function automatic logic [2:0] lead_len(input logic [7:0] lead);
    priority if (lead[7] == 1'b0) begin
      return 3'd1;
    end else if ((lead & 8'hE0) == 8'hC0) begin
      return 3'd2;
    end else if ((lead & 8'hF0) == 8'hE0) begin
      return 3'd3;
    end else if ((lead & 8'hF8) == 8'hF0) begin
      return 3'd4;
    end else begin
      return 3'd1;
    end
  endfunction

  function automatic logic lead_bad(input logic [7:0] lead);
    return !((lead[7] == 1'b0) || ((lead & 8'hE0) == 8'hC0) ||
             ((lead & 8'hF0) == 8'hE0) || ((lead & 8'hF8) == 8'hF0));
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] len);
    logic [31:0] m;
    unique case (len)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/ucdc_cell.sv =====
module ucdc_cell
  import ucdc_pkg::*;
#(
  parameter int CODE = 1
) (
  input  logic   clk,
  input  logic   rst,
  input  bcast_t bcast,
  input  tok_t   tok_in,
  output tok_t   tok_out
);

  localparam logic [7:0] IDX = 8'(CODE);

  logic [31:0] entry_bytes;
  logic [2:0]  entry_len;
  logic        enc_match;
  logic        dec_match;
  tok_t        tok_next;

  always_comb begin
    enc_match = bcast.is_enc && (IDX < bcast.next_code) &&
                (entry_len == bcast.key_len) && (entry_bytes == bcast.key_val);
    dec_match = bcast.is_dec && (bcast.code_in == IDX);
    tok_next  = tok_in;
    if (enc_match && !tok_in.hit) begin
      tok_next.hit  = 1'b1;
      tok_next.code = IDX;
    end
    if (dec_match) begin
      tok_next.bytes = (entry_len == 3'd0) ? 32'd0 : entry_bytes;
      tok_next.len   = entry_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_len <= 3'd0;
    end else if (bcast.we && (bcast.next_code == IDX)) begin
      entry_len <= bcast.key_len;
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.we && (bcast.next_code == IDX)) begin
      entry_bytes <= bcast.key_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/ucdc_chain.sv =====
module ucdc_chain
  import ucdc_pkg::*;
#(
  parameter int NUM_CELLS = CODE_LIMIT_DEF - 1
) (
  input  logic   clk,
  input  logic   rst,
  input  bcast_t bcast,
  input  tok_t   tok_in,
  output tok_t   tok_out
);

  tok_t links [NUM_CELLS+1];

  assign links[0] = tok_in;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    ucdc_cell #(
      .CODE(g + FIRST_FREE_CODE)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .bcast  (bcast),
      .tok_in (links[g]),
      .tok_out(links[g+1])
    );
  end

  assign tok_out = links[NUM_CELLS];

endmodule

// ===== rtl/utf8_char_dictionary_coder.sv =====
// Dictionary coder that maps UTF-8 characters to one-byte codes. Each code
// from 1 to CODE_LIMIT-1 owns one cell in a chain; an encode or decode sends a
// probe item down the chain, one cell per cycle, and every cell compares or
// reads its own entry as the probe passes. An encode or decode registers a
// launch flag, passes the probe through every cell and registers its result;
// a clear or an unused opcode goes straight to the done state, which waits
// while a valid result is stalled. One item is in the block at a time: the
// next item is accepted from the cycle after its result is registered. A clear
// erases no stored entry: it only rewinds the next free code.
module utf8_char_dictionary_coder
  import ucdc_pkg::*;
#(
  parameter int CODE_LIMIT = CODE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] char_bytes,
  input  logic [7:0]  code_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  code_out,
  output logic [31:0] char_out,
  output logic [2:0]  char_len,
  output logic        was_new,
  output logic        full_flag,
  output logic        bad_lead
);

  localparam int         NUM_CELLS = CODE_LIMIT - FIRST_FREE_CODE;
  localparam logic [7:0] LIMIT     = 8'(CODE_LIMIT);
  localparam logic [7:0] FIRST     = 8'(FIRST_FREE_CODE);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t      state;
  logic        launch;
  logic        is_enc;
  logic        is_dec;
  logic [31:0] key_val;
  logic [2:0]  key_len;
  logic        key_bad;
  logic [7:0]  code_r;
  logic [7:0]  next_code;

  logic [7:0]  res_code;
  logic [31:0] res_char;
  logic [2:0]  res_len;
  logic        res_new;
  logic        res_full;
  logic        res_bad;

  logic        in_acc;
  logic [2:0]  in_len;
  logic        we;
  bcast_t      bcast;
  tok_t        tok_head;
  tok_t        tok_tail;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_len   = lead_len(char_bytes[7:0]);

  assign we = (state == S_SEARCH) && tok_tail.active && is_enc && !tok_tail.hit &&
              (next_code < LIMIT);

  always_comb begin
    bcast.is_enc    = is_enc;
    bcast.is_dec    = is_dec;
    bcast.key_val   = key_val;
    bcast.key_len   = key_len;
    bcast.code_in   = code_r;
    bcast.next_code = next_code;
    bcast.we        = we;
    tok_head.active = launch;
    tok_head.hit    = 1'b0;
    tok_head.code   = 8'd0;
    tok_head.bytes  = 32'd0;
    tok_head.len    = 3'd0;
  end

  ucdc_chain #(
    .NUM_CELLS(NUM_CELLS)
  ) u_chain (
    .clk    (clk),
    .rst    (rst),
    .bcast  (bcast),
    .tok_in (tok_head),
    .tok_out(tok_tail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      is_enc    <= 1'b0;
      is_dec    <= 1'b0;
      next_code <= FIRST;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            is_enc   <= (opcode == OP_ENCODE);
            is_dec   <= (opcode == OP_DECODE);
            key_val  <= char_bytes & byte_mask(in_len);
            key_len  <= in_len;
            key_bad  <= lead_bad(char_bytes[7:0]);
            code_r   <= code_in;
            res_code <= 8'd0;
            res_char <= 32'd0;
            res_len  <= 3'd0;
            res_new  <= 1'b0;
            res_full <= 1'b0;
            res_bad  <= 1'b0;
            unique case (op_t'(opcode))
              OP_ENCODE, OP_DECODE: begin
                launch <= 1'b1;
                state  <= S_SEARCH;
              end
              OP_CLEAR: begin
                next_code <= FIRST;
                state     <= S_DONE;
              end
              OP_NONE: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SEARCH: begin
          launch <= 1'b0;
          if (tok_tail.active) begin
            if (is_enc) begin
              res_char <= key_val;
              res_len  <= key_len;
              res_bad  <= key_bad;
              priority if (tok_tail.hit) begin
                res_code <= tok_tail.code;
              end else if (next_code < LIMIT) begin
                res_code  <= next_code;
                res_new   <= 1'b1;
                next_code <= next_code + 8'd1;
              end else begin
                res_code <= FULL_CODE;
                res_full <= 1'b1;
              end
            end else begin
              res_code <= code_r;
              res_char <= tok_tail.bytes;
              res_len  <= tok_tail.len;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            code_out  <= res_code;
            char_out  <= res_char;
            char_len  <= res_len;
            was_new   <= res_new;
            full_flag <= res_full;
            bad_lead  <= res_bad;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ucdc_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEMS_PER_PHASE = 232;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] chars;
    logic [2:0]  len;
    logic        is_new;
    logic        full;
    logic        bad;
  } res_t;

  typedef struct {
    op_t         op;
    logic [31:0] chars;
    logic [7:0]  code;
    bit          typed;
    res_t        want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = 2'd0;
  logic [31:0] char_bytes = 32'd0;
  logic [7:0]  code_in = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  code_out;
  logic [31:0] char_out;
  logic [2:0]  char_len;
  logic        was_new;
  logic        full_flag;
  logic        bad_lead;

  utf8_char_dictionary_coder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .char_bytes (char_bytes),
    .code_in    (code_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_out   (code_out),
    .char_out   (char_out),
    .char_len   (char_len),
    .was_new    (was_new),
    .full_flag  (full_flag),
    .bad_lead   (bad_lead)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] dict_bytes [256] = '{default: '0};
  logic [2:0]  dict_len [256] = '{default: '0};
  bit          known [256] = '{default: 1'b0};
  int          next_free = FIRST_FREE_CODE;

  res_t        coded_q [$];
  logic [31:0] seen_chars [$];
  logic [7:0]  known_codes [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int cycles = 0;
  int n_enc = 0;
  int n_dec = 0;
  int n_clr = 0;
  int n_new = 0;
  int n_full = 0;
  int n_bad = 0;
  int idle_by_phase [4] = '{0, 68, 0, 32};
  int stall_by_phase [4] = '{0, 0, 68, 32};

  dir_row_t dir_rows [26] = '{
    '{OP_ENCODE, 32'h0000_0041, 8'h00, 1'b1, '{8'd1, 32'h0000_0041, 3'd1, 1'b1, 1'b0, 1'b0}},
    '{OP_ENCODE, 32'hFFFF_FF41, 8'hFF, 1'b1, '{8'd1, 32'h0000_0041, 3'd1, 1'b0, 1'b0, 1'b0}},
    '{OP_ENCODE, 32'h0000_A9C3, 8'h00, 1'b1, '{8'd2, 32'h0000_A9C3, 3'd2, 1'b1, 1'b0, 1'b0}},
    '{OP_ENCODE, 32'h00AC_82E2, 8'h00, 1'b1, '{8'd3, 32'h00AC_82E2, 3'd3, 1'b1, 1'b0, 1'b0}},
    '{OP_ENCODE, 32'h8D88_9FF0, 8'h00, 1'b1, '{8'd4, 32'h8D88_9FF0, 3'd4, 1'b1, 1'b0, 1'b0}},
    '{OP_ENCODE, 32'h0000_0080, 8'h00, 1'b1, '{8'd5, 32'h0000_0080, 3'd1, 1'b1, 1'b0, 1'b1}},
    '{OP_ENCODE, 32'hFFFF_FFFF, 8'h00, 1'b1, '{8'd6, 32'h0000_00FF, 3'd1, 1'b1, 1'b0, 1'b1}},
    '{OP_ENCODE, 32'h0000_00F8, 8'h00, 1'b1, '{8'd7, 32'h0000_00F8, 3'd1, 1'b1, 1'b0, 1'b1}},
    '{OP_ENCODE, 32'h1234_5600, 8'h00, 1'b0, '0},
    '{OP_ENCODE, 32'h0000_007F, 8'h00, 1'b0, '0},
    '{OP_ENCODE, 32'hFFFF_FFF7, 8'h00, 1'b0, '0},
    '{OP_ENCODE, 32'h0000_BFDF, 8'h00, 1'b0, '0},
    '{OP_ENCODE, 32'h00BF_BFEF, 8'h00, 1'b0, '0},
    '{OP_DECODE, 32'h0000_0000, 8'd3, 1'b1, '{8'd3, 32'h00AC_82E2, 3'd3, 1'b0, 1'b0, 1'b0}},
    '{OP_DECODE, 32'hFFFF_FFFF, 8'd4, 1'b1, '{8'd4, 32'h8D88_9FF0, 3'd4, 1'b0, 1'b0, 1'b0}},
    '{OP_DECODE, 32'h0000_0000, 8'd1, 1'b1, '{8'd1, 32'h0000_0041, 3'd1, 1'b0, 1'b0, 1'b0}},
    '{OP_DECODE, 32'hFFFF_FFFF, 8'h00, 1'b1, '0},
    '{OP_DECODE, 32'h0000_0000, 8'hFF, 1'b1, '{8'hFF, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{OP_NONE,   32'hFFFF_FFFF, 8'hFF, 1'b1, '0},
    '{OP_CLEAR,  32'hFFFF_FFFF, 8'hFF, 1'b1, '0},
    '{OP_ENCODE, 32'h00AC_82E2, 8'h00, 1'b1, '{8'd1, 32'h00AC_82E2, 3'd3, 1'b1, 1'b0, 1'b0}},
    '{OP_DECODE, 32'h0000_0000, 8'd2, 1'b1, '{8'd2, 32'h0000_A9C3, 3'd2, 1'b0, 1'b0, 1'b0}},
    '{OP_DECODE, 32'h0000_0000, 8'd1, 1'b1, '{8'd1, 32'h00AC_82E2, 3'd3, 1'b0, 1'b0, 1'b0}},
    '{OP_ENCODE, 32'h0000_0041, 8'h00, 1'b1, '{8'd2, 32'h0000_0041, 3'd1, 1'b1, 1'b0, 1'b0}},
    '{OP_DECODE, 32'h0000_0000, 8'd12, 1'b0, '0},
    '{OP_ENCODE, 32'h00BF_BFEF, 8'h00, 1'b0, '0}
  };

  function automatic res_t predict_coding(op_t op, logic [31:0] chars, logic [7:0] code);
    res_t        r;
    logic [2:0]  n;
    logic [31:0] m;
    logic [31:0] v;
    bit          found;
    r = '0;
    found = 1'b0;
    case (op)
      OP_ENCODE: begin
        casez (chars[7:0])
          8'b0???????: n = 3'd1;
          8'b110?????: n = 3'd2;
          8'b1110????: n = 3'd3;
          8'b11110???: n = 3'd4;
          default: begin
            n = 3'd1;
            r.bad = 1'b1;
          end
        endcase
        m = (n == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
        v = chars & m;
        for (int c = FIRST_FREE_CODE; c < next_free; c++) begin
          if (!found && dict_len[c] == n && dict_bytes[c] == v) begin
            found = 1'b1;
            r.code = 8'(c);
          end
        end
        if (!found) begin
          if (next_free < CODE_LIMIT_DEF) begin
            r.code = 8'(next_free);
            r.is_new = 1'b1;
            dict_bytes[next_free] = v;
            dict_len[next_free] = n;
            if (!known[next_free]) begin
              known[next_free] = 1'b1;
              known_codes.push_back(8'(next_free));
            end
            next_free++;
          end else begin
            r.code = FULL_CODE;
            r.full = 1'b1;
          end
        end
        r.chars = v;
        r.len = n;
      end
      OP_DECODE: begin
        r.code = code;
        r.len = dict_len[code];
        r.chars = (dict_len[code] == 3'd0) ? 32'd0 : dict_bytes[code];
      end
      OP_CLEAR: next_free = FIRST_FREE_CODE;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_char();
    logic [31:0] w;
    int          n;
    w = $urandom;
    n = $urandom_range(1, 4);
    if ($urandom_range(99) < 20) return w;
    case (n)
      1: w[7] = 1'b0;
      2: w[7:5] = 3'b110;
      3: w[7:4] = 4'b1110;
      default: w[7:3] = 5'b11110;
    endcase
    for (int b = 1; b < n; b++) w[8 * b + 7 -: 2] = 2'b10;
    return w;
  endfunction

  task automatic send_item(op_t op, logic [31:0] chars, logic [7:0] code, bit typed,
                           res_t want);
    res_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    char_bytes <= chars;
    code_in <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_coding(op, chars, code);
    coded_q.push_back(typed ? want : pred);
    case (op)
      OP_ENCODE: n_enc++;
      OP_DECODE: n_dec++;
      OP_CLEAR:  n_clr++;
      default: ;
    endcase
  endtask

  task automatic random_item(bit clears_ok);
    int          r;
    logic [31:0] ch;
    r = $urandom_range(99);
    if (r < 10 && seen_chars.size() > 0) begin
      send_item(OP_ENCODE, seen_chars[$urandom_range(seen_chars.size() - 1)], 8'($urandom),
                1'b0, '0);
    end else if (r < 25 && known_codes.size() > 0) begin
      send_item(OP_DECODE, $urandom, known_codes[$urandom_range(known_codes.size() - 1)],
                1'b0, '0);
    end else if (r < 27) begin
      send_item(OP_NONE, $urandom, 8'($urandom), 1'b0, '0);
    end else if (r < 30 && clears_ok) begin
      send_item(OP_CLEAR, $urandom, 8'($urandom), 1'b0, '0);
    end else begin
      ch = rand_char();
      seen_chars.push_back(ch);
      send_item(OP_ENCODE, ch, 8'($urandom), 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (coded_q.size() != 0);
  endtask

  task automatic compare_result(res_t want);
    if (code_out !== want.code) begin
      $error("code_out: expected %0h, got %0h", want.code, code_out);
      errors++;
    end
    if (char_out !== want.chars) begin
      $error("char_out: expected %08h, got %08h", want.chars, char_out);
      errors++;
    end
    if (char_len !== want.len) begin
      $error("char_len: expected %0d, got %0d", want.len, char_len);
      errors++;
    end
    if (was_new !== want.is_new) begin
      $error("was_new: expected %0b, got %0b", want.is_new, was_new);
      errors++;
    end
    if (full_flag !== want.full) begin
      $error("full_flag: expected %0b, got %0b", want.full, full_flag);
      errors++;
    end
    if (bad_lead !== want.bad) begin
      $error("bad_lead: expected %0b, got %0b", want.bad, bad_lead);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  res_t oldest;

  always @(posedge clk) begin
    if (!rst) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (coded_q.size() == 0) begin
          $error("result with none pending: code_out=%0h char_out=%08h", code_out, char_out);
          errors++;
        end else begin
          oldest = coded_q.pop_front();
          compare_result(oldest);
          n_new += oldest.is_new;
          n_full += oldest.full;
          n_bad += oldest.bad;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].chars, dir_rows[i].code, dir_rows[i].typed,
                dir_rows[i].want);
    end
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int k = 0; k < ITEMS_PER_PHASE; k++) random_item(ph >= 2);
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("coded %0d encodes, %0d decodes, %0d clears over four idle/stall mixes",
             n_enc, n_dec, n_clr);
    $display("saw %0d new codes, %0d table-full results, %0d bad leads", n_new, n_full, n_bad);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ucdc_pkg.sv
rtl/ucdc_cell.sv
rtl/ucdc_chain.sv
rtl/utf8_char_dictionary_coder.sv
test/tb_top.sv
